>>> rtl/euler_to_quaternion_core_macros.svh
// assertion macros shared by the euler-to-quaternion rtl
// depends on nothing; included by the top level
`ifndef EULER_TO_QUATERNION_CORE_MACROS_SVH
`define EULER_TO_QUATERNION_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define E2Q_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("e2q check failed");

// next-cycle implication checked outside reset
`define E2Q_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("e2q check failed");

`endif

>>> rtl/e2q_pkg.sv
// constants, types and helpers for the euler-to-quaternion core
// depends on nothing
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int CordicStages = 16;
  localparam int OutFracBits  = 14;
  localparam int TableLen     = 24;
  localparam int NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;
  // cordic word: q2.30 values and 2^-24 degree angles up to 256 degrees
  localparam int CW = 34;
  localparam int AngW = 17;
  localparam int OutW = 16;
  localparam logic signed [CW-1:0] GainInv = 34'sd652032874;
  localparam logic signed [CW-1:0] Deg90   = 34'sd1509949440;
  localparam logic signed [CW-1:0] Deg180  = 34'sd3019898880;

  typedef logic signed [CW-1:0] word_t;

  // one rotation lane of the cordic
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  neg;
  } rot_t;

  function automatic word_t atan_deg(input int i);
    word_t t;
    begin
      unique case (i)
        0: t = 34'sd754974720;   1: t = 34'sd445687602;
        2: t = 34'sd235489088;   3: t = 34'sd119537938;
        4: t = 34'sd60000934;    5: t = 34'sd30029717;
        6: t = 34'sd15018523;    7: t = 34'sd7509720;
        8: t = 34'sd3754917;     9: t = 34'sd1877466;
        10: t = 34'sd938734;     11: t = 34'sd469367;
        12: t = 34'sd234684;     13: t = 34'sd117342;
        14: t = 34'sd58671;      15: t = 34'sd29335;
        16: t = 34'sd14668;      17: t = 34'sd7334;
        18: t = 34'sd3667;       19: t = 34'sd1833;
        20: t = 34'sd917;        21: t = 34'sd458;
        22: t = 34'sd229;        23: t = 34'sd115;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  // product of two q2.30 values rounded back to q2.30
  function automatic word_t mul30(input word_t a, input word_t b);
    logic signed [2*CW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< 29);
      return p[CW+29:30];
    end
  endfunction
endpackage

>>> rtl/euler_to_quaternion_core.sv
// euler angles to unit quaternion, fully pipelined
// depends on e2q_pkg, e2q_cordic and euler_to_quaternion_core_macros.svh
//
// channel | dir | tdata fields (low to high)
// in_*    | in  | angle_x[16:0], angle_y[33:17], angle_z[50:34], 56-bit word
// out_*   | out | quat_w, quat_x, quat_y, quat_z, 16 bits each, 64-bit word
//
// one request accepted per cycle while the pipe advances; registered stages in order
// (fold, cordic stages, pair products, triple products, sums, output register)
// the whole pipe advances when the output register is empty or being taken
// a stall freezes every stage; nothing is dropped or repeated
// synchronous active-low reset clears only the valid bits
`timescale 1ns / 1ps
`include "euler_to_quaternion_core_macros.svh"
module euler_to_quaternion_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // angle_x, angle_y, angle_z, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // fold each half angle into +-90 degrees; lanes: 0 from y, 1 from -z, 2 from x
  rot_t [2:0] fold;
  always_comb begin
    logic signed [AngW-1:0] a [3];
    word_t z;
    a[0] = in_tdata[33:17];
    a[1] = -in_tdata[50:34];
    a[2] = in_tdata[16:0];
    for (int l = 0; l < 3; l++) begin
      z = {{(CW-AngW-16){a[l][AngW-1]}}, a[l], 16'b0};
      if (l == 1 && in_tdata[50:34] == 17'h10000) z = 34'sd4294967296;
      fold[l].neg = 1'b0;
      if (z > Deg90) begin
        z = z - Deg180; fold[l].neg = 1'b1;
      end else if (z < -Deg90) begin
        z = z + Deg180; fold[l].neg = 1'b1;
      end
      fold[l].x = GainInv;
      fold[l].y = '0;
      fold[l].z = z;
    end
  end

  logic           cv;
  word_t [2:0]    cc, ss;
  e2q_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_tvalid),
    .in_rot(fold), .out_v(cv), .out_c(cc), .out_s(ss)
  );

  // pair products of lanes 0 and 1, lane 2 carried along
  word_t c1c2_r, s1s2_r, s1c2_r, c1s2_r, c3_r, s3_r;
  logic  p1_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else if (adv) p1_v_r <= cv;
    if (adv) begin
      c1c2_r <= mul30(cc[0], cc[1]);
      s1s2_r <= mul30(ss[0], ss[1]);
      s1c2_r <= mul30(ss[0], cc[1]);
      c1s2_r <= mul30(cc[0], ss[1]);
      c3_r   <= cc[2];
      s3_r   <= ss[2];
    end
  end

  // eight triple products
  word_t [7:0] t_r;
  logic        p2_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else if (adv) p2_v_r <= p1_v_r;
    if (adv) begin
      t_r[0] <= mul30(c1c2_r, c3_r); t_r[1] <= mul30(s1s2_r, s3_r);
      t_r[2] <= mul30(c1c2_r, s3_r); t_r[3] <= mul30(s1s2_r, c3_r);
      t_r[4] <= mul30(s1c2_r, c3_r); t_r[5] <= mul30(c1s2_r, s3_r);
      t_r[6] <= mul30(c1s2_r, c3_r); t_r[7] <= mul30(s1c2_r, s3_r);
    end
  end

  // combine into the four parts
  logic signed [CW:0] sum_r [4];
  logic               p3_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p3_v_r <= 1'b0;
    else if (adv) p3_v_r <= p2_v_r;
    if (adv) begin
      sum_r[0] <= CW'(0) + t_r[0] - t_r[1];
      sum_r[1] <= CW'(0) + t_r[2] + t_r[3];
      sum_r[2] <= CW'(0) + t_r[4] + t_r[5];
      sum_r[3] <= CW'(0) + t_r[6] - t_r[7];
    end
  end

  // round, clamp and register the result
  logic [63:0] out_nxt;
  always_comb begin
    logic signed [CW:0] r;
    localparam logic signed [CW:0] Lim = (CW+1)'(1) <<< OutFracBits;
    for (int k = 0; k < 4; k++) begin
      r = (sum_r[k] + ((CW+1)'(1) <<< (29 - OutFracBits))) >>> (30 - OutFracBits);
      if (r > Lim) r = Lim;
      if (r < -Lim) r = -Lim;
      out_nxt[k*OutW +: OutW] = r[OutW-1:0];
    end
  end

  logic [63:0] out_r;
  logic        out_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= p3_v_r;
    if (adv) out_r <= out_nxt;
  end
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  `E2Q_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready)
  `E2Q_ASSERT_NEXT(a_hold_on_stall, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `E2Q_ASSERT_NEXT(a_sum_feeds_out, adv && p3_v_r, out_tvalid)
endmodule

>>> rtl/e2q_cordic.sv
// pipelined rotation-mode cordic: one stage per iteration, three lanes
// depends on e2q_pkg
`timescale 1ns / 1ps
module e2q_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  e2q_pkg::rot_t [2:0]  in_rot,
  output logic                 out_v,
  output e2q_pkg::word_t [2:0] out_c,
  output e2q_pkg::word_t [2:0] out_s
);
  import e2q_pkg::*;

  rot_t [2:0] stg_r [NumStages+1];
  logic       vld_r [NumStages+1];

  // stage 0 takes the reduced lane state
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_v;
    if (adv) stg_r[0] <= in_rot;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    rot_t [2:0] nxt;
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        nxt[l].neg = stg_r[i][l].neg;
        if (!stg_r[i][l].z[CW-1]) begin
          nxt[l].x = stg_r[i][l].x - (stg_r[i][l].y >>> i);
          nxt[l].y = stg_r[i][l].y + (stg_r[i][l].x >>> i);
          nxt[l].z = stg_r[i][l].z - atan_deg(i);
        end else begin
          nxt[l].x = stg_r[i][l].x + (stg_r[i][l].y >>> i);
          nxt[l].y = stg_r[i][l].y - (stg_r[i][l].x >>> i);
          nxt[l].z = stg_r[i][l].z + atan_deg(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (adv) vld_r[i+1] <= vld_r[i];
      if (adv) stg_r[i+1] <= nxt;
    end
  end

  // undo the half-turn fold
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_c[l] = stg_r[NumStages][l].neg ? -stg_r[NumStages][l].x : stg_r[NumStages][l].x;
      out_s[l] = stg_r[NumStages][l].neg ? -stg_r[NumStages][l].y : stg_r[NumStages][l].y;
    end
  end
  assign out_v = vld_r[NumStages];
endmodule

>>> bench/euler_to_quaternion_core_test.sv
// self-checking bench for euler_to_quaternion_core: angle triples in, quaternions out
// depends on e2q_pkg and the euler_to_quaternion_core rtl
`timescale 1ns / 1ps
module euler_to_quaternion_core_test;
  import e2q_pkg::*;

  localparam int Latency    = 1 + CordicStages + 4;
  localparam int IdleLimit  = 20000;
  localparam int RandomReqs = 2000;
  localparam int AngMax     = 46080;

  typedef logic signed [63:0] wide_t;
  typedef struct packed {
    logic [15:0] qz;
    logic [15:0] qy;
    logic [15:0] qx;
    logic [15:0] qw;
  } quat_t;
  typedef struct {
    int ax;
    int ay;
    int az;
  } triple_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  quat_t   pending_quats[$];
  triple_t stim_rows[$];
  int      errors;
  int      sent;
  int      received;
  int      idle_cycles;
  int      out_pattern;

  euler_to_quaternion_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic wide_t floor_sh(wide_t v, int s);
    return v >>> s;
  endfunction

  function automatic wide_t round_sh(wide_t v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic wide_t qmul(wide_t a, wide_t b);
    logic signed [127:0] p;
    p = a * b;
    p = (p + (128'sd1 <<< 29)) >>> 30;
    return wide_t'(p);
  endfunction

  // cosine and sine of half the angle, q2.30
  function automatic void half_angle_trig(input wide_t ang, output wide_t c,
                                          output wide_t s);
    wide_t z, x, y, dx, dy, tbl[24];
    logic fold;
    tbl = '{64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938,
            64'sd60000934, 64'sd30029717, 64'sd15018523, 64'sd7509720,
            64'sd3754917, 64'sd1877466, 64'sd938734, 64'sd469367,
            64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335,
            64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
            64'sd917, 64'sd458, 64'sd229, 64'sd115};
    z = ang * 65536;
    x = 64'sd652032874;
    y = 0;
    fold = 1'b0;
    if (z > (64'sd90 <<< 24)) begin
      z -= 64'sd180 <<< 24;
      fold = 1'b1;
    end else if (z < -(64'sd90 <<< 24)) begin
      z += 64'sd180 <<< 24;
      fold = 1'b1;
    end
    for (int i = 0; i < NumStages; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= tbl[i];
      end else begin
        x += dx; y -= dy; z += tbl[i];
      end
    end
    if (fold) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic logic [15:0] to_out(wide_t v);
    wide_t r, lim;
    lim = 64'sd1 <<< OutFracBits;
    r = round_sh(v, 30 - OutFracBits);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quat(triple_t t);
    wide_t c1, s1, c2, s2, c3, s3, cc, ss, sc, cs;
    quat_t q;
    half_angle_trig(t.ay, c1, s1);
    half_angle_trig(-t.az, c2, s2);
    half_angle_trig(t.ax, c3, s3);
    cc = qmul(c1, c2); ss = qmul(s1, s2);
    sc = qmul(s1, c2); cs = qmul(c1, s2);
    q.qw = to_out(qmul(cc, c3) - qmul(ss, s3));
    q.qx = to_out(qmul(cc, s3) + qmul(ss, c3));
    q.qy = to_out(qmul(sc, c3) + qmul(cs, s3));
    q.qz = to_out(qmul(cs, c3) - qmul(sc, s3));
    return q;
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? AngMax : -AngMax;
      1: return $signed($urandom_range(0, 2 * 23040)) - 23040;
      2: return $signed($urandom_range(0, 255)) - 128;
      3: return $urandom_range(0, 1) ? -65536 : 65535;
      4: return $signed($urandom_range(0, 131071)) - 65536;
      default: return $signed($urandom_range(0, 2 * AngMax)) - AngMax;
    endcase
  endfunction

  // sender: bursts with random gaps, one request per accepted edge
  initial begin
    triple_t t;
    int burst;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    errors = 0; sent = 0;
    // directed rows: zero, extremes, fold boundaries, full range of the field
    stim_rows.push_back('{0, 0, 0});
    stim_rows.push_back('{AngMax, 0, 0});
    stim_rows.push_back('{0, AngMax, 0});
    stim_rows.push_back('{0, 0, AngMax});
    stim_rows.push_back('{-AngMax, -AngMax, -AngMax});
    stim_rows.push_back('{AngMax, AngMax, AngMax});
    stim_rows.push_back('{23040, 23040, 23040});
    stim_rows.push_back('{-23040, -23040, -23040});
    stim_rows.push_back('{23041, -23041, 23041});
    stim_rows.push_back('{11520, 0, 0});
    stim_rows.push_back('{0, 11520, 0});
    stim_rows.push_back('{0, 0, 11520});
    stim_rows.push_back('{65535, -65536, 65535});
    stim_rows.push_back('{-65536, 65535, -65536});
    stim_rows.push_back('{1, -1, 1});
    stim_rows.push_back('{46079, 11520, -46079});
    stim_rows.push_back('{-11520, 5760, 34560});
    for (int i = 0; i < RandomReqs; i++)
      stim_rows.push_back('{rand_angle(), rand_angle(), rand_angle()});
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    burst = 0;
    while (stim_rows.size() > 0) begin
      if (burst == 0) begin
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge clk);
        burst = $urandom_range(1, 40);
      end
      t = stim_rows.pop_front();
      in_tdata  = {5'b0, t.az[16:0], t.ay[16:0], t.ax[16:0]};
      in_tvalid = 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      pending_quats.push_back(predict_quat(t));
      sent++;
      burst--;
      @(negedge clk);
      if (burst == 0 || stim_rows.size() == 0) in_tvalid = 1'b0;
    end
  end

  // receiver stalls on a pattern of its own
  initial begin
    out_tready  = 1'b0;
    out_pattern = 0;
    forever begin
      @(negedge clk);
      out_pattern++;
      case ((out_pattern / 300) % 3)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        default: out_tready = ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // result checker and idle watchdog
  initial begin
    quat_t got, want;
    received = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata;
        received++;
        if (pending_quats.size() == 0) begin
          $error("result with no request pending: %h", got);
          errors++;
        end else begin
          want = pending_quats.pop_front();
          if (got.qw !== want.qw) begin
            $error("quat_w expected %h actual %h", want.qw, got.qw); errors++;
          end
          if (got.qx !== want.qx) begin
            $error("quat_x expected %h actual %h", want.qx, got.qx); errors++;
          end
          if (got.qy !== want.qy) begin
            $error("quat_y expected %h actual %h", want.qy, got.qy); errors++;
          end
          if (got.qz !== want.qz) begin
            $error("quat_z expected %h actual %h", want.qz, got.qz); errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    wait (rst_n === 1'b1);
    wait (stim_rows.size() == 0 && in_tvalid === 1'b0);
    wait (pending_quats.size() == 0);
    repeat (Latency * 4) @(posedge clk);
    if (pending_quats.size() != 0) errors++;
    $display("sent %0d angle triples, checked %0d quaternions", sent, received);
    $display("covered field extremes, half-angle folding and random stalls on both sides");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_cordic.sv
rtl/euler_to_quaternion_core.sv
bench/euler_to_quaternion_core_test.sv
